[rtl/csc_pkg.sv]
package csc_pkg;

   localparam int FLAGS_WIDTH = 3;
   localparam int FLAG_CAPSULE_AWAKE = 0;
   localparam int FLAG_SPHERE_AWAKE = 1;
   localparam int FLAG_RELOAD = 2;
   localparam int BUDGET_WIDTH = 16;
   localparam logic [BUDGET_WIDTH-1:0] BUDGET_RESET = 16'd256;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [4:0] {
      BACK_IDLE,
      BACK_DOT_MUL,
      BACK_DOT_ACC,
      BACK_PROJ_CHK,
      BACK_T_DIV,
      BACK_PROJ_MUL,
      BACK_PROJ_ACC,
      BACK_DIST_MUL,
      BACK_DIST_ACC,
      BACK_RAD_MUL,
      BACK_RAD_CHK,
      BACK_SQRT,
      BACK_NRM_SETUP,
      BACK_NRM_DIV,
      BACK_PT_MUL,
      BACK_PT_ACC,
      BACK_DONE
   } back_state_type;

endpackage

[rtl/csc_front.sv]
module csc_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic q_full,
   output logic q_push,
   input  logic take,
   input  logic [csc_pkg::FLAGS_WIDTH-1:0] take_flags,
   input  logic [csc_pkg::BUDGET_WIDTH-1:0] budget,
   output logic test_go,
   input  logic hit_done
);
   import csc_pkg::*;

   logic [COUNT_WIDTH-1:0] remaining_ff, remaining_in, eff;
   logic [COUNT_WIDTH-1:0] budget_ext;

   if (COUNT_WIDTH >= BUDGET_WIDTH) begin : g_wide
      assign budget_ext = COUNT_WIDTH'(budget);
   end else begin : g_narrow
      assign budget_ext = budget[COUNT_WIDTH-1:0];
   end

   assign in_ready = !q_full;
   assign q_push = in_valid && in_ready;
   assign eff = take_flags[FLAG_RELOAD] ? budget_ext : remaining_ff;
   assign test_go = (eff != '0) &&
                    (take_flags[FLAG_CAPSULE_AWAKE] || take_flags[FLAG_SPHERE_AWAKE]);

   always_comb begin
      remaining_in = remaining_ff;
      if (take) remaining_in = eff;
      if (hit_done) remaining_in = remaining_in - COUNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) remaining_ff <= COUNT_WIDTH'(BUDGET_RESET);
      else remaining_ff <= remaining_in;
   end
endmodule

[rtl/capsule_sphere_contact_top.sv]
// Capsule-sphere contact generator, Q16.16. One request is taken into a two-entry
// queue; the back end works one request at a time and takes the next only after the
// result register has drained. The budget counter in the front end is reloaded and
// tested as the back end takes a request, and drops when a hit completes. A request
// that cannot hit (budget used up or both bodies asleep) goes from idle straight to
// the done state and from there into the result register. A full test runs the dot
// products, the t division, the projection and distance, the radius check, the
// square root, a division per normal component and the point, with coordinates in
// Q16.16 at the default widths, on the shared one-bit-per-cycle divider and
// square-root loop. With t clamped to 0 or 1 the t division is skipped. A miss at
// the distance test ends after the radius check.
module capsule_sphere_contact_top #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // top_x,top_y,top_z,bottom_x,bottom_y,bottom_z,center_x,center_y,center_z,
   // capsule_radius,sphere_radius,flags (low to high), zero padded
   input  logic [((9*COORD_WIDTH+2*(COORD_WIDTH-1)+3+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit,normal_x,normal_y,normal_z,point_x,point_y,point_z,depth, zero padded
   output logic [((1+3*(FRAC_BITS+2)+3*COORD_WIDTH+COORD_WIDTH-1+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [csc_pkg::BUDGET_WIDTH-1:0] csr_data
);
   import csc_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int RW = CW - 1;
   localparam int NW = FRAC_BITS + 2;
   localparam int IW = 9*CW + 2*RW + 3;
   localparam int OW = 1 + 3*NW + 3*CW + RW;
   localparam int OPW = ((OW + 7) / 8) * 8;
   localparam int PW = 2*CW + 4;
   localparam int DW = PW + FRAC_BITS + 2;
   localparam int SQW = CW + 1;
   localparam logic signed [CW+1:0] PT_MAX = $signed({3'b000, {(CW-1){1'b1}}});
   localparam logic signed [CW+1:0] PT_MIN = $signed({3'b111, {(CW-1){1'b0}}});

   logic [BUDGET_WIDTH-1:0] budget_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) budget_ff <= BUDGET_RESET;
      else if (csr_valid) budget_ff <= csr_data;
   end

   logic test_go, hit_done, q_push, q_full, q_empty, q_pop, take;
   logic [IW-1:0] q_mem [2];
   logic [1:0] q_cnt_ff;
   logic q_wr_ff, q_rd_ff;
   logic [IW-1:0] item;

   csc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .q_full(q_full), .q_push(q_push), .take(take),
      .take_flags(item[IW-1 -: FLAGS_WIDTH]), .budget(budget_ff),
      .test_go(test_go), .hit_done(hit_done));

   assign q_full = q_cnt_ff == 2'd2;
   assign q_empty = q_cnt_ff == 2'd0;
   always_ff @(posedge clock) begin
      if (q_push) q_mem[q_wr_ff] <= req_tdata[IW-1:0];
      if (reset) begin
         q_cnt_ff <= '0; q_wr_ff <= 1'b0; q_rd_ff <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_ff + 2'(q_push) - 2'(q_pop);
         if (q_push) q_wr_ff <= !q_wr_ff;
         if (q_pop) q_rd_ff <= !q_rd_ff;
      end
   end

   assign item = q_mem[q_rd_ff];

   back_state_type st_ff, st_in;
   logic signed [CW:0] a_ff [3], c_ff [3], d_ff [3], w_ff [3], v_ff [3];
   logic signed [PW-1:0] acc_ff, dd_ff, wd_ff;
   logic signed [PW-1:0] prod_ff;
   logic [1:0] idx_ff;
   logic [RW:0] r_ff;
   logic [RW-1:0] rs_ff;
   logic [FRAC_BITS:0] t_ff;
   logic [DW-1:0] num_ff, rem_ff, quo_ff, den_ff;
   logic [7:0] cnt_ff;
   logic [SQW-1:0] len_ff;
   logic [RW-1:0] depth_ff;
   logic signed [NW-1:0] nrm_ff [3];
   logic signed [CW-1:0] pt_ff [3];
   logic hit_ff;
   logic out_valid_ff;
   logic [OW-1:0] out_ff;

   logic signed [CW:0] ma, mb;
   logic signed [2*CW+1:0] mp;
   always_comb begin
      ma = '0; mb = '0;
      unique case (st_ff)
         BACK_DOT_MUL: begin
            ma = d_ff[idx_ff];
            mb = acc_ff[0] ? w_ff[idx_ff] : d_ff[idx_ff];
         end
         BACK_PROJ_MUL: begin ma = d_ff[idx_ff]; mb = (CW+1)'(t_ff); end
         BACK_DIST_MUL: begin ma = v_ff[idx_ff]; mb = v_ff[idx_ff]; end
         BACK_RAD_MUL: begin ma = $signed({1'b0, r_ff}); mb = $signed({1'b0, r_ff}); end
         BACK_PT_MUL: begin
            ma = (CW+1)'(nrm_ff[idx_ff]);
            mb = $signed({1'b0, rs_ff}) - $signed({2'b0, depth_ff});
         end
         default: ;
      endcase
   end
   assign mp = ma * mb;

   logic phase_ff;
   logic [DW-1:0] rem_sh, rem_sub;
   logic [2*SQW-1:0] sq_cand;
   logic [SQW-1:0] len_try;
   logic signed [PW-1:0] s_full;
   logic signed [CW+1:0] pt_sum;
   logic [CW:0] mag_v;

   assign rem_sh = {rem_ff[DW-2:0], num_ff[DW-1]};
   assign rem_sub = rem_sh - den_ff;
   assign len_try = len_ff | (SQW'(1) << cnt_ff);
   assign sq_cand = len_try * len_try;
   assign s_full = acc_ff;
   assign mag_v = v_ff[idx_ff][CW] ? (CW+1)'(-v_ff[idx_ff]) : (CW+1)'(v_ff[idx_ff]);
   assign pt_sum = (CW+2)'(c_ff[idx_ff]) + (CW+2)'(prod_ff >>> FRAC_BITS) +
                   (CW+2)'((prod_ff[PW-1] && prod_ff[FRAC_BITS-1:0] != '0) ? 1 : 0);

   assign take = (st_ff == BACK_IDLE) && !q_empty && !out_valid_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BACK_IDLE: if (take) st_in = test_go ? BACK_DOT_MUL : BACK_DONE;
         BACK_DOT_MUL: st_in = BACK_DOT_ACC;
         BACK_DOT_ACC: if (idx_ff == 2'd2 && acc_ff[0]) st_in = BACK_PROJ_CHK;
                       else st_in = BACK_DOT_MUL;
         BACK_PROJ_CHK: st_in = BACK_T_DIV;
         BACK_T_DIV: if (cnt_ff == 8'd0) st_in = BACK_PROJ_MUL;
         BACK_PROJ_MUL: st_in = BACK_PROJ_ACC;
         BACK_PROJ_ACC: st_in = (idx_ff == 2'd2) ? BACK_DIST_MUL : BACK_PROJ_MUL;
         BACK_DIST_MUL: st_in = BACK_DIST_ACC;
         BACK_DIST_ACC: st_in = (idx_ff == 2'd2) ? BACK_RAD_MUL : BACK_DIST_MUL;
         BACK_RAD_MUL: st_in = BACK_RAD_CHK;
         BACK_RAD_CHK: st_in = (s_full < prod_ff) ? BACK_SQRT : BACK_DONE;
         BACK_SQRT: if (cnt_ff == 8'd0) st_in = BACK_NRM_SETUP;
         BACK_NRM_SETUP: st_in = BACK_NRM_DIV;
         BACK_NRM_DIV: if (cnt_ff == 8'd0) st_in = (idx_ff == 2'd2) ? BACK_PT_MUL : BACK_NRM_SETUP;
         BACK_PT_MUL: st_in = BACK_PT_ACC;
         BACK_PT_ACC: st_in = (idx_ff == 2'd2) ? BACK_DONE : BACK_PT_MUL;
         BACK_DONE: st_in = BACK_IDLE;
         default: st_in = BACK_IDLE;
      endcase
   end

   assign q_pop = st_ff == BACK_DONE;
   assign hit_done = q_pop && hit_ff;

   function automatic logic [SQW-1:0] len_try_ok(input logic ok,
                                                 input logic [SQW-1:0] tried,
                                                 input logic [SQW-1:0] kept);
      return ok ? tried : kept;
   endfunction

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mp);
      unique case (st_ff)
         BACK_IDLE: begin
            hit_ff <= test_go;
            idx_ff <= '0;
            acc_ff <= '0;
            dd_ff <= '0;
            wd_ff <= '0;
            phase_ff <= 1'b0;
            for (int i = 0; i < 3; i++) begin
               a_ff[i] <= (CW+1)'($signed(item[i*CW +: CW]));
               c_ff[i] <= (CW+1)'($signed(item[(6+i)*CW +: CW]));
               d_ff[i] <= (CW+1)'($signed(item[(3+i)*CW +: CW])) -
                          (CW+1)'($signed(item[i*CW +: CW]));
               w_ff[i] <= (CW+1)'($signed(item[(6+i)*CW +: CW])) -
                          (CW+1)'($signed(item[i*CW +: CW]));
               nrm_ff[i] <= '0;
               pt_ff[i] <= '0;
            end
            r_ff <= (RW+1)'(item[9*CW +: RW]) + (RW+1)'(item[9*CW+RW +: RW]);
            rs_ff <= item[9*CW+RW +: RW];
            depth_ff <= '0;
         end
         BACK_DOT_MUL: ;
         BACK_DOT_ACC: begin
            if (acc_ff[0]) wd_ff <= wd_ff + prod_ff;
            else dd_ff <= dd_ff + prod_ff;
            acc_ff[0] <= !acc_ff[0];
            if (acc_ff[0]) idx_ff <= idx_ff + 2'd1;
         end
         BACK_PROJ_CHK: begin
            idx_ff <= '0;
            num_ff <= DW'(wd_ff) << (DW - PW);
            rem_ff <= '0;
            quo_ff <= '0;
            den_ff <= DW'(dd_ff);
            cnt_ff <= 8'(PW - 1);
            if (dd_ff == '0 || wd_ff <= 0) begin
               t_ff <= '0; cnt_ff <= '0;
            end else if (wd_ff >= dd_ff) begin
               t_ff <= (FRAC_BITS+1)'(1) << FRAC_BITS; cnt_ff <= '0;
            end else begin
               t_ff <= '0;
               cnt_ff <= 8'(PW + FRAC_BITS - 1);
            end
            phase_ff <= !(dd_ff == '0 || wd_ff <= 0 || wd_ff >= dd_ff);
         end
         BACK_T_DIV: if (phase_ff) begin
            num_ff <= num_ff << 1;
            if (rem_sh >= den_ff) begin
               rem_ff <= rem_sub; quo_ff <= {quo_ff[DW-2:0], 1'b1};
               if (cnt_ff == 8'd0) t_ff <= {quo_ff[FRAC_BITS-1:0], 1'b1};
            end else begin
               rem_ff <= rem_sh; quo_ff <= {quo_ff[DW-2:0], 1'b0};
               if (cnt_ff == 8'd0) t_ff <= {quo_ff[FRAC_BITS-1:0], 1'b0};
            end
            if (cnt_ff != 8'd0) cnt_ff <= cnt_ff - 8'd1;
         end
         BACK_PROJ_MUL: acc_ff <= '0;
         BACK_PROJ_ACC: begin
            v_ff[idx_ff] <= a_ff[idx_ff] - c_ff[idx_ff] +
               (CW+1)'((prod_ff >>> FRAC_BITS) +
               ((prod_ff[PW-1] && prod_ff[FRAC_BITS-1:0] != '0) ? 1 : 0));
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         BACK_DIST_MUL: ;
         BACK_DIST_ACC: begin
            acc_ff <= acc_ff + prod_ff;
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         BACK_RAD_MUL: ;
         BACK_RAD_CHK: begin
            hit_ff <= s_full < prod_ff;
            len_ff <= '0;
            cnt_ff <= 8'(SQW - 1);
         end
         BACK_SQRT: begin
            if (PW'(sq_cand) <= s_full) len_ff <= len_try;
            if (cnt_ff != 8'd0) cnt_ff <= cnt_ff - 8'd1;
            else depth_ff <= RW'(((RW+2)'(r_ff) - (RW+2)'(len_try_ok(PW'(sq_cand) <= s_full,
                             len_try, len_ff))) >> 1);
         end
         BACK_NRM_SETUP: begin
            num_ff <= DW'(mag_v) << (DW - CW - 1);
            rem_ff <= '0;
            den_ff <= DW'(len_ff);
            cnt_ff <= 8'(CW + FRAC_BITS);
            quo_ff <= '0;
         end
         BACK_NRM_DIV: begin
            num_ff <= num_ff << 1;
            rem_ff <= (rem_sh >= den_ff) ? rem_sub : rem_sh;
            quo_ff <= {quo_ff[DW-2:0], rem_sh >= den_ff};
            if (cnt_ff != 8'd0) cnt_ff <= cnt_ff - 8'd1;
            else begin
               if (len_ff == '0) nrm_ff[idx_ff] <= '0;
               else if (DW'(mag_v) >= DW'(len_ff))
                  nrm_ff[idx_ff] <= v_ff[idx_ff][CW] ? -(NW'(1) << FRAC_BITS)
                                                      : (NW'(1) << FRAC_BITS);
               else nrm_ff[idx_ff] <= v_ff[idx_ff][CW] ? -NW'({quo_ff[DW-2:0], rem_sh >= den_ff})
                                                       : NW'({quo_ff[DW-2:0], rem_sh >= den_ff});
               idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            end
         end
         BACK_PT_MUL: ;
         BACK_PT_ACC: begin
            if (pt_sum > PT_MAX)
               pt_ff[idx_ff] <= {1'b0, {(CW-1){1'b1}}};
            else if (pt_sum < PT_MIN)
               pt_ff[idx_ff] <= {1'b1, {(CW-1){1'b0}}};
            else pt_ff[idx_ff] <= CW'(pt_sum);
            idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
         end
         BACK_DONE: ;
         default: ;
      endcase
      if (reset) st_ff <= BACK_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (q_pop) out_valid_ff <= 1'b1;
      else if (rsp_tready) out_valid_ff <= 1'b0;
      if (q_pop) begin
         if (hit_ff)
            out_ff <= {depth_ff, pt_ff[2], pt_ff[1], pt_ff[0],
                       nrm_ff[2], nrm_ff[1], nrm_ff[0], 1'b1};
         else out_ff <= '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = OPW'(out_ff);

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("push to full queue");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped");
endmodule

[tb/capsule_sphere_contact_checker.sv]
`timescale 1ns / 1ps

module capsule_sphere_contact_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [359:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [183:0] rsp_tdata,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [csc_pkg::BUDGET_WIDTH-1:0] csr_data,
   output int errors,
   output int pending
);
   import csc_pkg::*;

   localparam longint ONE = 64'sd65536;
   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;

   typedef struct {
      logic hit;
      logic signed [17:0] nrm [3];
      logic signed [31:0] pt [3];
      logic [30:0] depth;
   } contact_type;

   contact_type expected_contacts [$];
   logic [BUDGET_WIDTH-1:0] budget;
   logic [15:0] contacts_left;

   function automatic longint scale_q(longint a, longint b);
      logic signed [127:0] sa, sb;
      logic [127:0] pr;
      sa = a;
      sb = b;
      pr = (sa < 0 ? -sa : sa) * (sb < 0 ? -sb : sb);
      pr = pr >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(pr[61:0]) : longint'(pr[61:0]);
   endfunction

   function automatic longint unsigned floor_sqrt(logic [127:0] s);
      longint unsigned res, c;
      res = 0;
      for (int b = 62; b >= 0; b--) begin
         c = res | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) res = c;
      end
      return res;
   endfunction

   function automatic contact_type predict_contact(logic [359:0] item);
      contact_type e;
      longint a [3], p [3], d [3], v [3], nrm [3];
      logic signed [127:0] dd, wd, s, x, y;
      longint t, k, c;
      longint unsigned rc, rs, r, len, depth, m;
      logic [2:0] flags;
      e.hit = 0;
      e.depth = 0;
      for (int i = 0; i < 3; i++) begin
         e.nrm[i] = 0;
         e.pt[i] = 0;
      end
      rc = item[318:288];
      rs = item[349:319];
      flags = item[352:350];
      if (flags[FLAG_RELOAD]) contacts_left = budget;
      if (contacts_left == 0) return e;
      if (!flags[FLAG_CAPSULE_AWAKE] && !flags[FLAG_SPHERE_AWAKE]) return e;
      dd = 0;
      wd = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(item[32*i +: 32]));
         p[i] = longint'($signed(item[32*(6+i) +: 32]));
         d[i] = longint'($signed(item[32*(3+i) +: 32])) - a[i];
         x = d[i];
         y = p[i] - a[i];
         dd += x * x;
         wd += y * x;
      end
      if (dd == 0 || wd <= 0) t = 0;
      else if (wd >= dd) t = ONE;
      else begin
         x = (wd <<< 16) / dd;
         t = longint'(x[63:0]);
      end
      for (int i = 0; i < 3; i++) begin
         v[i] = a[i] + scale_q(d[i], t) - p[i];
         x = v[i];
         s += x * x;
      end
      r = rc + rs;
      x = {64'd0, r};
      if (s >= x * x) return e;
      len = floor_sqrt(s);
      depth = (r - len) >> 1;
      for (int i = 0; i < 3; i++) begin
         m = v[i] < 0 ? -v[i] : v[i];
         if (len == 0) nrm[i] = 0;
         else if (m >= len) nrm[i] = ONE;
         else nrm[i] = longint'((m << 16) / len);
         if (v[i] < 0) nrm[i] = -nrm[i];
         k = longint'(rs) - longint'(depth);
         c = p[i] + scale_q(nrm[i], k);
         if (c > CMAX) c = CMAX;
         if (c < CMIN) c = CMIN;
         e.nrm[i] = nrm[i][17:0];
         e.pt[i] = c[31:0];
      end
      contacts_left = contacts_left - 1;
      e.hit = 1;
      e.depth = depth[30:0];
      return e;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      contact_type e;
      if (reset) begin
         budget = BUDGET_RESET;
         contacts_left = BUDGET_RESET;
         expected_contacts.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) budget = csr_data;
         if (req_tvalid && req_tready) expected_contacts.push_back(predict_contact(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_contacts.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               e = expected_contacts.pop_front();
               if (rsp_tdata[0] !== e.hit) report("hit", rsp_tdata[0], e.hit);
               for (int i = 0; i < 3; i++) begin
                  if (rsp_tdata[1+18*i +: 18] !== e.nrm[i])
                     report("normal", $signed(rsp_tdata[1+18*i +: 18]), e.nrm[i]);
                  if (rsp_tdata[55+32*i +: 32] !== e.pt[i])
                     report("point", $signed(rsp_tdata[55+32*i +: 32]), e.pt[i]);
               end
               if (rsp_tdata[181:151] !== e.depth) report("depth", rsp_tdata[181:151], e.depth);
            end
         end
      end
      pending = expected_contacts.size();
   end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import csc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_valid, csr_ready;
   logic [359:0] req_tdata;
   logic [183:0] rsp_tdata;
   logic [BUDGET_WIDTH-1:0] csr_data;
   int errors, pending, stall_left;
   bit quiet;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   capsule_sphere_contact_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   capsule_sphere_contact_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   // hold off the response side in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   function automatic logic [359:0] pack(input int tx, ty, tz, bx, by, bz, cx, cy, cz,
                                         input logic [30:0] rc, rs, input logic [2:0] fl);
      return {7'd0, fl, rs, rc, cz, cy, cx, bz, by, bx, tz, ty, tx};
   endfunction

   function automatic int near_coord();
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   function automatic logic [359:0] random_request();
      int c [9];
      logic [30:0] rc, rs;
      logic [2:0] fl;
      fl = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) fl[FLAG_RELOAD] = 0;
      if ($urandom_range(0, 9) < 2) begin
         for (int i = 0; i < 9; i++) c[i] = $urandom;
         rc = 31'($urandom);
         rs = 31'($urandom);
      end else begin
         for (int i = 0; i < 9; i++) c[i] = near_coord();
         if ($urandom_range(0, 9) == 0) for (int i = 3; i < 6; i++) c[i] = c[i-3];
         rc = 31'($urandom_range(0, 1048576));
         rs = 31'($urandom_range(0, 1048576));
      end
      return pack(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], rc, rs, fl);
   endfunction

   task automatic send_request(input logic [359:0] item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tdata <= item;
      req_tvalid <= 1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(input logic [BUDGET_WIDTH-1:0] value);
      csr_data <= value;
      csr_valid <= 1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      logic [BUDGET_WIDTH-1:0] budgets [5];
      budgets = '{16'd0, 16'hFFFF, 16'd5, 16'd0, 16'd256};
      budgets[3] = 16'($urandom);
      req_tvalid <= 0;
      req_tdata <= '0;
      csr_valid <= 0;
      csr_data <= '0;
      rsp_tready <= 1;
      stall_left = 0;
      quiet = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 65536, 0, 65536, 65536, 3'b011));
      send_request(pack(0, 0, 0, 655360, 0, 0, -131072, 32768, 0, 65536, 65536, 3'b001));
      send_request(pack(0, 0, 0, 655360, 0, 0, 786432, 0, 32768, 65536, 65536, 3'b010));
      send_request(pack(65536, 65536, 65536, 65536, 65536, 65536, 98304, 65536, 65536,
                        65536, 65536, 3'b011));
      send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 0, 0, 65536, 65536, 3'b011));
      send_request(pack(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b011));
      send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 65536, 0, 65536, 65536, 3'b000));
      send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 6553600, 0, 65536, 65536, 3'b011));
      send_request(pack(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        31'h7FFFFFFF, 31'h7FFFFFFF, 3'b111));
      send_request(pack(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        31'h7FFFFFFF, 31'h7FFFFFFF, 3'b011));
      send_request(pack(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFF000, 0, 0,
                        31'h7FFFFFFF, 0, 3'b010));
      send_request(pack(0, 0, 0, 0, 0, 0, 0, 0, 65536, 0, 31'h7FFFFFFF, 3'b001));
      drain();
      write_budget(16'd2);
      send_request(pack(0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 65536, 3'b111));
      for (int i = 0; i < 3; i++)
         send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 65536, 0, 65536, 65536, 3'b011));
      send_request(pack(0, 0, 0, 655360, 0, 0, 327680, 65536, 0, 65536, 65536, 3'b111));
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_budget(budgets[ph]);
         if (ph == 4) quiet = 1;
         for (int i = 0; i < 350; i++) send_request(random_request());
         drain();
      end
      repeat (20) @(posedge clock);
      if (errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("testbench failed");
      $finish;
   end
endmodule
